@@ rtl/humidity_temp_frame_decoder_core_macros.svh @@
// assertion macros for the humidity and temperature frame decoder
`ifndef HUMIDITY_TEMP_FRAME_DECODER_CORE_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define HTFD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define HTFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/htfd_pkg.sv @@
// shared types, constants and functions of the frame decoder
package htfd_pkg;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	localparam logic [2:0] IDX_STATUS = 3'd0;
	localparam logic [2:0] IDX_CRC    = 3'd6;
	localparam logic [2:0] IDX_IDLE   = 3'd7;

	localparam int RAW_W   = 20;
	localparam int HUM_W   = 14;
	localparam int TMP_W   = 15;
	localparam int HPROD_W = RAW_W + HUM_W;
	localparam int TPROD_W = RAW_W + TMP_W;

	localparam logic [HUM_W-1:0] HUM_SCALE  = 14'd10000;
	localparam logic [TMP_W-1:0] TMP_SCALE  = 15'd20000;
	localparam logic [TMP_W-1:0] TMP_OFFSET = 15'd5000;

	localparam int MQ_DEPTH = 2;
	localparam int MQ_AW    = (MQ_DEPTH > 1) ? $clog2(MQ_DEPTH) : 1;
	localparam int MQ_CW    = $clog2(MQ_DEPTH + 1);

	typedef struct packed {
		logic             crc_bad;
		logic [7:0]       status;
		logic [RAW_W-1:0] raw_h;
		logic [RAW_W-1:0] raw_t;
	} frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} mq_stat_t;

	// one byte of crc-8, msb first
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/humidity_temp_frame_decoder_core.sv @@
// top level of the humidity and temperature frame decoder
// throughput: one byte item per cycle while full is low, with no bubbles between frames
// a result goes through the frame queue, scale stage and result register to the ports
// full rises only when the two-entry frame queue is full and the back end is stalled by pop
// reset: arst_n clears the byte count, crc (to 0xFF), queue pointers and valid flags at once
// the first byte after reset is taken as the status byte even without frame_start
`include "humidity_temp_frame_decoder_core_macros.svh"
module humidity_temp_frame_decoder_core import htfd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// input item side
	input  logic                    push,
	output logic                    full,
	input  logic [7:0]              rx_byte,
	input  logic                    frame_start,
	// result item side
	output logic                    empty,
	input  logic                    pop,
	output logic                    frame_status,
	output logic [7:0]              status_raw,
	output logic                    sensor_busy,
	output logic [HUM_W-1:0]        humidity_centi,
	output logic signed [TMP_W-1:0] temperature_centi
);

	// frame records passed from front to back
	mq_stat_t mq_stat;
	logic     mq_wr;
	logic     mq_rd;
	frame_t   mq_wr_data;
	frame_t   mq_rd_data;

	// front: counts bytes, runs the crc, gathers the two 20-bit raw fields
	htfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.rx_byte    (rx_byte),
		.frame_start(frame_start),
		.full       (full),
		.mq_stat    (mq_stat),
		.mq_wr      (mq_wr),
		.mq_wr_data (mq_wr_data)
	);

	// short queue so the front keeps taking bytes while results wait
	htfd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (mq_wr),
		.wr_data(mq_wr_data),
		.rd     (mq_rd),
		.rd_data(mq_rd_data),
		.stat   (mq_stat)
	);

	// back: constant-scale multiplies in one stage, then offset and the result register
	htfd_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.mq_stat          (mq_stat),
		.mq_rd_data       (mq_rd_data),
		.mq_rd            (mq_rd),
		.empty            (empty),
		.pop              (pop),
		.frame_status     (frame_status),
		.status_raw       (status_raw),
		.sensor_busy      (sensor_busy),
		.humidity_centi   (humidity_centi),
		.temperature_centi(temperature_centi)
	);

	// a crc failure must carry zero values
	`HTFD_ASSERT_IMPL(a_bad_zero, clk, arst_n, !empty && frame_status, (humidity_centi == '0) && (temperature_centi == '0), "crc failure with nonzero values")
	// scaled humidity stays below 100 percent
	`HTFD_ASSERT_IMPL(a_hum_range, clk, arst_n, !empty, humidity_centi <= 14'd9999, "humidity out of range")
	// scaled temperature stays within the sensor span
	`HTFD_ASSERT_IMPL(a_tmp_range, clk, arst_n, !empty, ($signed(temperature_centi) >= -15'sd5000) && ($signed(temperature_centi) <= 15'sd14999), "temperature out of range")
	// the queue is never written while full
	`HTFD_ASSERT_IMPL(a_mq_no_ovf, clk, arst_n, mq_wr, !mq_stat.full, "frame queue overflow")

endmodule

@@ rtl/htfd_front.sv @@
// front end: byte counting, crc and field collection, one frame record per frame
module htfd_front import htfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] rx_byte,
	input  logic       frame_start,
	output logic       full,
	input  mq_stat_t   mq_stat,
	output logic       mq_wr,
	output frame_t     mq_wr_data
);

	logic [2:0]         byte_index_q;
	logic [7:0]         crc_q;
	logic [2*RAW_W-1:0] shift_q;
	logic [7:0]         status_q;

	logic       accept;
	logic [2:0] idx_eff;
	logic [7:0] crc_eff;
	logic [7:0] crc_next;

	assign full    = mq_stat.full;
	assign accept  = push && !mq_stat.full;
	assign idx_eff = frame_start ? IDX_STATUS : byte_index_q;
	assign crc_eff = frame_start ? CRC_INIT : crc_q;
	assign crc_next = crc8_step(crc_eff, rx_byte);

	assign mq_wr              = accept && (idx_eff == IDX_CRC);
	assign mq_wr_data.crc_bad = (rx_byte != crc_q);
	assign mq_wr_data.status  = status_q;
	assign mq_wr_data.raw_h   = shift_q[2*RAW_W-1:RAW_W];
	assign mq_wr_data.raw_t   = shift_q[RAW_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= IDX_STATUS;
			crc_q        <= CRC_INIT;
			shift_q      <= '0;
			status_q     <= '0;
		end else if (accept) begin
			// start flag: crc restart is already folded into crc_eff
			if (frame_start) begin
				shift_q <= '0;
			end
			if (idx_eff < IDX_CRC) begin
				crc_q        <= crc_next;
				byte_index_q <= idx_eff + 3'd1;
				if (idx_eff == IDX_STATUS) begin
					status_q <= rx_byte;
				end else begin
					shift_q <= {shift_q[2*RAW_W-9:0], rx_byte};
				end
			end else if (idx_eff == IDX_CRC) begin
				byte_index_q <= IDX_IDLE;
			end else begin
				byte_index_q <= IDX_IDLE;
			end
		end
	end

endmodule

@@ rtl/htfd_fifo.sv @@
// short register queue of frame records between front and back
module htfd_fifo import htfd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr,
	input  frame_t   wr_data,
	input  logic     rd,
	output frame_t   rd_data,
	output mq_stat_t stat
);

	frame_t            mem_q [MQ_DEPTH];
	logic [MQ_AW-1:0]  wptr_q;
	logic [MQ_AW-1:0]  rptr_q;
	logic [MQ_CW-1:0]  count_q;
	logic              do_wr;
	logic              do_rd;

	assign stat.full  = (count_q == MQ_CW'(MQ_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_wr      = wr && !stat.full;
	assign do_rd      = rd && !stat.empty;
	assign rd_data    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == MQ_AW'(MQ_DEPTH - 1)) ? '0 : wptr_q + MQ_AW'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == MQ_AW'(MQ_DEPTH - 1)) ? '0 : rptr_q + MQ_AW'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + MQ_CW'(1);
				2'b01:   count_q <= count_q - MQ_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/htfd_back.sv @@
// back end: scaling multiplies, offset, error zeroing and the result register
module htfd_back import htfd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mq_stat_t                mq_stat,
	input  frame_t                  mq_rd_data,
	output logic                    mq_rd,
	output logic                    empty,
	input  logic                    pop,
	output logic                    frame_status,
	output logic [7:0]              status_raw,
	output logic                    sensor_busy,
	output logic [HUM_W-1:0]        humidity_centi,
	output logic signed [TMP_W-1:0] temperature_centi
);

	logic               v_s1;
	logic               bad_s1;
	logic [7:0]         status_s1;
	logic [HPROD_W-1:0] hprod_s1;
	logic [TPROD_W-1:0] tprod_s1;

	logic               out_v_q;
	logic               bad_q;
	logic [7:0]         status_q;
	logic [HUM_W-1:0]   hum_q;
	logic [TMP_W-1:0]   tmp_q;

	logic               out_ready;
	logic               s1_ready;
	logic [TMP_W-1:0]   tmp_floor;

	assign out_ready = !out_v_q || pop;
	assign s1_ready  = !v_s1 || out_ready;
	assign mq_rd     = !mq_stat.empty && s1_ready;
	assign tmp_floor = tprod_s1[TPROD_W-1:RAW_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				v_s1 <= !mq_stat.empty;
			end
			if (v_s1 && out_ready) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mq_rd) begin
			bad_s1    <= mq_rd_data.crc_bad;
			status_s1 <= mq_rd_data.status;
			hprod_s1  <= HPROD_W'(mq_rd_data.raw_h) * HPROD_W'(HUM_SCALE);
			tprod_s1  <= TPROD_W'(mq_rd_data.raw_t) * TPROD_W'(TMP_SCALE);
		end
		if (v_s1 && out_ready) begin
			bad_q    <= bad_s1;
			status_q <= status_s1;
			hum_q    <= bad_s1 ? '0 : hprod_s1[HPROD_W-1:RAW_W];
			tmp_q    <= bad_s1 ? '0 : tmp_floor - TMP_OFFSET;
		end
	end

	assign empty             = !out_v_q;
	assign frame_status      = bad_q;
	assign status_raw        = status_q;
	assign sensor_busy       = status_q[7];
	assign humidity_centi    = hum_q;
	assign temperature_centi = $signed(tmp_q);

endmodule
